// File: hdl/ispcs_pkg.sv
// ispcs_pkg: types and constants shared by the programmer command sequencer
// holds word structs, command/status structs and all command, mode and state codes
// no dependencies
`timescale 1ns / 1ps

package ispcs_pkg;

    // input word modes
    localparam logic [1:0] MODE_SETUP = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // setup function codes
    localparam logic [7:0] FN_CONNECT    = 8'd1;
    localparam logic [7:0] FN_DISCONNECT = 8'd2;
    localparam logic [7:0] FN_TRANSMIT   = 8'd3;
    localparam logic [7:0] FN_RDFLASH    = 8'd4;
    localparam logic [7:0] FN_ENPROG     = 8'd5;
    localparam logic [7:0] FN_WRFLASH    = 8'd6;
    localparam logic [7:0] FN_RDEEPROM   = 8'd7;
    localparam logic [7:0] FN_WREEPROM   = 8'd8;
    localparam logic [7:0] FN_LONGADDR   = 8'd9;

    // target command codes
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_CONNECT   = 4'd1;
    localparam logic [3:0] CMD_DISCONN   = 4'd2;
    localparam logic [3:0] CMD_TRANSMIT  = 4'd3;
    localparam logic [3:0] CMD_ENTERPROG = 4'd4;
    localparam logic [3:0] CMD_RDFLASH   = 4'd5;
    localparam logic [3:0] CMD_RDEEPROM  = 4'd6;
    localparam logic [3:0] CMD_WRFL_BUF  = 4'd7;
    localparam logic [3:0] CMD_WRFL_IMM  = 4'd8;
    localparam logic [3:0] CMD_FLUSH     = 4'd9;
    localparam logic [3:0] CMD_WREEPROM  = 4'd10;

    // transfer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WRFLASH  = 3'd1;
    localparam logic [2:0] ST_RDFLASH  = 3'd2;
    localparam logic [2:0] ST_RDEEPROM = 3'd3;
    localparam logic [2:0] ST_WREEPROM = 3'd4;

    // setup reply lengths
    localparam logic [7:0] RLEN_NONE  = 8'd0;
    localparam logic [7:0] RLEN_ONE   = 8'd1;
    localparam logic [7:0] RLEN_FOUR  = 8'd4;
    localparam logic [7:0] RLEN_MULTI = 8'd255;

    // bytes per read packet on the host link
    localparam int PACKET_BYTES = 8;
    localparam logic [6:0] PKT_BYTES_W = 7'(PACKET_BYTES);
    localparam logic [3:0] READ_LIMIT  = 4'((PACKET_BYTES < 8) ? PACKET_BYTES : 8);

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  func;
        logic [15:0] w_value;
        logic [15:0] w_index;
        logic [15:0] w_length;
        logic [3:0]  packet_len;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] address;
        logic [7:0]  data;
        logic        sck_slow;
        logic [7:0]  reply_len;
        logic        refused;
        logic        transfer_done;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic item_void;
        logic word_last;
    } t_dp_status;

endpackage

// File: hdl/ispcs_dp.sv
// ispcs_dp: datapath of the command sequencer
// holds the transfer state, counters, item latch and the output word register
// depends on ispcs_pkg
`timescale 1ns / 1ps

module ispcs_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ispcs_pkg::t_in_word   i_in,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  ispcs_pkg::t_ctrl_cmd  i_cmd,
    output ispcs_pkg::t_dp_status o_status,
    output ispcs_pkg::t_out_word  o_out
);

    ispcs_pkg::t_in_word  r_item;
    ispcs_pkg::t_out_word r_out;
    ispcs_pkg::t_out_word w_word;

    logic [2:0]  r_k;
    logic        r_pf, n_pf;
    logic        r_ff, n_ff;
    logic        r_fin, n_fin;
    logic [2:0]  r_xfer, n_xfer;
    logic        r_long, n_long;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_brem, n_brem;
    logic [11:0] r_psize, n_psize;
    logic [3:0]  r_flags, n_flags;
    logic [11:0] r_pcnt, n_pcnt;
    logic        r_slow;

    logic        w_last;
    logic [11:0] pc_dec;
    logic [11:0] pc_new;
    logic [15:0] br_dec;
    logic [11:0] ps_set;
    logic        pf, fin, ff;
    logic [3:0]  rd_n;
    logic        rd_done;
    logic        rd_state;
    logic        wr_state;

    always_comb begin
        n_pf    = r_pf;
        n_ff    = r_ff;
        n_fin   = r_fin;
        n_xfer  = r_xfer;
        n_long  = r_long;
        n_addr  = r_addr;
        n_brem  = r_brem;
        n_psize = r_psize;
        n_flags = r_flags;
        n_pcnt  = r_pcnt;
        w_word  = '0;
        w_last  = 1'b1;

        pc_dec   = r_pcnt - 12'd1;
        br_dec   = r_brem - 16'd1;
        ps_set   = {r_item.w_index[15:12], r_item.w_index[7:0]};
        rd_state = r_xfer inside {ispcs_pkg::ST_RDFLASH, ispcs_pkg::ST_RDEEPROM};
        wr_state = r_xfer inside {ispcs_pkg::ST_WRFLASH, ispcs_pkg::ST_WREEPROM};
        rd_n     = (r_item.packet_len > ispcs_pkg::READ_LIMIT) ?
                   ispcs_pkg::READ_LIMIT : r_item.packet_len;
        rd_done  = {3'b000, r_item.packet_len} < ispcs_pkg::PKT_BYTES_W;

        // write byte bookkeeping, used on the first word of a write item
        pf     = 1'b0;
        pc_new = r_pcnt;
        if (r_xfer == ispcs_pkg::ST_WRFLASH && r_psize != 12'd0) begin
            pf     = (pc_dec == 12'd0);
            pc_new = pf ? r_psize : pc_dec;
        end
        fin = (br_dec == 16'd0);
        ff  = fin && r_flags[1] && (pc_new != r_psize);

        case (r_item.mode)
            ispcs_pkg::MODE_SETUP: begin
                case (r_item.func)
                    ispcs_pkg::FN_CONNECT: begin
                        n_long          = 1'b0;
                        w_word.cmd      = ispcs_pkg::CMD_CONNECT;
                        w_word.sck_slow = r_slow;
                    end
                    ispcs_pkg::FN_DISCONNECT: begin
                        w_word.cmd = ispcs_pkg::CMD_DISCONN;
                    end
                    ispcs_pkg::FN_TRANSMIT: begin
                        w_word.cmd       = ispcs_pkg::CMD_TRANSMIT;
                        w_word.reply_len = ispcs_pkg::RLEN_FOUR;
                        case (r_k[1:0])
                            2'd0:    w_word.data = r_item.w_value[7:0];
                            2'd1:    w_word.data = r_item.w_value[15:8];
                            2'd2:    w_word.data = r_item.w_index[7:0];
                            default: w_word.data = r_item.w_index[15:8];
                        endcase
                        w_last = (r_k == 3'd3);
                    end
                    ispcs_pkg::FN_RDFLASH, ispcs_pkg::FN_RDEEPROM: begin
                        if (!r_long) begin
                            n_addr = {16'd0, r_item.w_value};
                        end
                        n_brem = r_item.w_length;
                        n_xfer = (r_item.func == ispcs_pkg::FN_RDFLASH) ?
                                 ispcs_pkg::ST_RDFLASH : ispcs_pkg::ST_RDEEPROM;
                        w_word.reply_len = ispcs_pkg::RLEN_MULTI;
                    end
                    ispcs_pkg::FN_ENPROG: begin
                        w_word.cmd       = ispcs_pkg::CMD_ENTERPROG;
                        w_word.reply_len = ispcs_pkg::RLEN_ONE;
                    end
                    ispcs_pkg::FN_WRFLASH: begin
                        n_psize = ps_set;
                        n_flags = r_item.w_index[11:8];
                        if (r_item.w_index[8]) begin
                            n_pcnt = ps_set;
                        end
                        if (!r_long) begin
                            n_addr = {16'd0, r_item.w_value};
                        end
                        n_brem = r_item.w_length;
                        n_xfer = ispcs_pkg::ST_WRFLASH;
                        w_word.reply_len = ispcs_pkg::RLEN_MULTI;
                    end
                    ispcs_pkg::FN_WREEPROM: begin
                        n_psize = 12'd0;
                        n_flags = 4'd0;
                        if (!r_long) begin
                            n_addr = {16'd0, r_item.w_value};
                        end
                        n_brem = r_item.w_length;
                        n_xfer = ispcs_pkg::ST_WREEPROM;
                        w_word.reply_len = ispcs_pkg::RLEN_MULTI;
                    end
                    ispcs_pkg::FN_LONGADDR: begin
                        n_long = 1'b1;
                        n_addr = {r_item.w_index, r_item.w_value};
                    end
                    default: begin
                        w_word.cmd = ispcs_pkg::CMD_NONE;
                    end
                endcase
            end
            ispcs_pkg::MODE_READ: begin
                if (!rd_state) begin
                    w_word.refused = 1'b1;
                end else if (rd_n == 4'd0) begin
                    w_word.transfer_done = rd_done;
                    n_xfer = ispcs_pkg::ST_IDLE;
                end else begin
                    w_word.cmd     = (r_xfer == ispcs_pkg::ST_RDFLASH) ?
                                     ispcs_pkg::CMD_RDFLASH : ispcs_pkg::CMD_RDEEPROM;
                    w_word.address = r_addr;
                    n_addr         = r_addr + 32'd1;
                    w_last         = ({1'b0, r_k} == (rd_n - 4'd1));
                    w_word.transfer_done = w_last && rd_done;
                    if (w_last && rd_done) begin
                        n_xfer = ispcs_pkg::ST_IDLE;
                    end
                end
            end
            ispcs_pkg::MODE_WRITE: begin
                w_word.address = r_addr;
                w_word.data    = r_item.data_byte;
                if (r_k == 3'd0 && !wr_state) begin
                    w_word.refused = 1'b1;
                    w_word.address = 32'd0;
                    w_word.data    = 8'd0;
                end else if (r_k == 3'd0) begin
                    // the data byte itself
                    if (r_xfer == ispcs_pkg::ST_WREEPROM) begin
                        w_word.cmd = ispcs_pkg::CMD_WREEPROM;
                    end else if (r_psize == 12'd0) begin
                        w_word.cmd = ispcs_pkg::CMD_WRFL_IMM;
                    end else begin
                        w_word.cmd = ispcs_pkg::CMD_WRFL_BUF;
                    end
                    n_pcnt = pc_new;
                    n_brem = br_dec;
                    if (fin) begin
                        n_xfer = ispcs_pkg::ST_IDLE;
                    end
                    n_pf  = pf;
                    n_ff  = ff;
                    n_fin = fin;
                    w_last = !pf && !ff;
                    w_word.transfer_done = fin && !pf && !ff;
                end else begin
                    // page full flush, then end of block flush
                    w_word.cmd = ispcs_pkg::CMD_FLUSH;
                    if (r_pf) begin
                        n_pf   = 1'b0;
                        w_last = !r_ff;
                        w_word.transfer_done = r_fin && !r_ff;
                    end else begin
                        n_ff   = 1'b0;
                        w_last = 1'b1;
                        w_word.transfer_done = r_fin;
                    end
                end
                if (wr_state || r_k != 3'd0) begin
                    if (w_last) begin
                        n_addr = r_addr + 32'd1;
                    end
                end
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
        w_word.last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 3'd0;
            r_pf    <= 1'b0;
            r_ff    <= 1'b0;
            r_fin   <= 1'b0;
            r_xfer  <= ispcs_pkg::ST_IDLE;
            r_long  <= 1'b0;
            r_addr  <= 32'd0;
            r_brem  <= 16'd0;
            r_psize <= 12'd0;
            r_flags <= 4'd0;
            r_pcnt  <= 12'd0;
            r_slow  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_slow <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_k <= 3'd0;
            end else if (i_cmd.step) begin
                r_k     <= r_k + 3'd1;
                r_pf    <= n_pf;
                r_ff    <= n_ff;
                r_fin   <= n_fin;
                r_xfer  <= n_xfer;
                r_long  <= n_long;
                r_addr  <= n_addr;
                r_brem  <= n_brem;
                r_psize <= n_psize;
                r_flags <= n_flags;
                r_pcnt  <= n_pcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.step) begin
            r_out <= w_word;
        end
    end

    assign o_status.item_void = (i_in.mode == ispcs_pkg::MODE_NONE);
    assign o_status.word_last = w_last;
    assign o_out              = r_out;

endmodule

// File: hdl/ispcs_ctrl.sv
// ispcs_ctrl: controller of the command sequencer
// handshakes both channels and paces the datapath one word per step
// depends on ispcs_pkg
`timescale 1ns / 1ps

module ispcs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  ispcs_pkg::t_dp_status i_status,
    output ispcs_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic CS_IDLE = 1'b0;
    localparam logic CS_RUN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;
    logic out_free;

    assign o_in_ready = (r_state == CS_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        case (r_state)
            CS_IDLE: begin
                if (accept && !i_status.item_void) begin
                    o_cmd.load = 1'b1;
                    n_state    = CS_RUN;
                end
            end
            CS_RUN: begin
                if (out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.word_last) begin
                        n_state = CS_IDLE;
                    end
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
        n_out_valid = o_cmd.step ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/isp_programmer_command_sequencer.sv
// isp_programmer_command_sequencer: host-side command engine of an in-system programmer
// an item is latched when taken and its result words are formed from the latch, the input staying closed
// until the last one is stepped; an item gives N result words (1 to 8), one word a cycle while the output
// side is not stalled, through the single output register; a MODE_NONE item is taken and gives no word
// reset: synchronous active-low i_rst_n clears the transfer state, counters and clock option
`timescale 1ns / 1ps

module isp_programmer_command_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words: setup requests, read packets, write bytes
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ispcs_pkg::t_in_word  i_in,
    // target command words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ispcs_pkg::t_out_word o_out,
    // clock option register, written only while idle by the user; the block does not enforce it
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data
);

    ispcs_pkg::t_ctrl_cmd  ctrl_cmd;
    ispcs_pkg::t_dp_status dp_status;

    // controller: takes a word, then steps the datapath until the last result
    ispcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (ctrl_cmd)
    );

    // datapath: transfer state, address and page counters, output register
    ispcs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (ctrl_cmd),
        .o_status      (dp_status),
        .o_out         (o_out)
    );

    // a real item keeps the input side closed on the next cycle
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.mode != ispcs_pkg::MODE_NONE) |=> !o_in_ready)
        else $error("input taken while previous word still in progress");

    // completion always closes the item's words
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.transfer_done) |-> o_out.last)
        else $error("transfer done on a word that is not last");

    // a refused packet gives one bare word
    a_refused_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.refused) |->
        (o_out.last && o_out.cmd == ispcs_pkg::CMD_NONE && !o_out.transfer_done))
        else $error("refused word carries a command");

endmodule
